/* hdl/swfl_pkg.sv */
`default_nettype none
package swfl_pkg;

   localparam int TIME_W   = 32;
   localparam int KEYID_W  = 8;
   localparam int WINDOW_W = 16;
   localparam int MAXF_W   = 5;
   localparam int STATUS_W = 2;
   localparam int RETRY_W  = 16;
   localparam int CSR_IDX_W = 1;

   // op codes
   localparam logic OP_ATTEMPT = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ALLOWED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAIL = 1'd1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd300;
   localparam logic [MAXF_W-1:0]   MAXF_RESET   = 5'd5;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [RETRY_W-1:0]  retry;
   } swfl_rsp_type;

endpackage
`default_nettype wire

/* hdl/swfl_front.sv */
`default_nettype none
module swfl_front
   import swfl_pkg::*;
#(
   parameter int KEY_SLOTS = 256,
   parameter int KW = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               clearing,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic [KEYID_W-1:0] req_key_id,
   input  wire logic [TIME_W-1:0]  req_now_ticks,
   output logic                    q_valid,
   output logic                    q_op,
   output logic [KW-1:0]           q_key,
   output logic [TIME_W-1:0]       q_now,
   input  wire logic               q_pop
);

   localparam int LUT_N = 2 ** KEYID_W;

   logic [KW-1:0]     key_lut [LUT_N];
   logic              op_ff   [2];
   logic [KW-1:0]     key_ff  [2];
   logic [TIME_W-1:0] now_ff  [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   // fold the key id onto the slot range
   always_comb begin
      for (int i = 0; i < LUT_N; i++) begin
         key_lut[i] = KW'(i % KEY_SLOTS);
      end
   end

   assign busy    = (cnt_ff == 2'd2) || clearing;
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_op    = op_ff[rd_ptr_ff];
   assign q_key   = key_ff[rd_ptr_ff];
   assign q_now   = now_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // hold the classified item in the queue
   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]  <= req_op;
         key_ff[wr_ptr_ff] <= key_lut[req_key_id];
         now_ff[wr_ptr_ff] <= req_now_ticks;
      end
   end

endmodule
`default_nettype wire

/* hdl/swfl_div.sv */
`default_nettype none
module swfl_div
   import swfl_pkg::*;
#(
   parameter int DIVISOR = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [TIME_W-1:0] dividend,
   output logic [RETRY_W-1:0]     quotient,
   output logic                   done
);

   // the dividend is an age inside the window, so below 65536 * DIVISOR
   localparam int SH = $clog2(DIVISOR);
   localparam int NW = RETRY_W + SH;
   localparam int MW = NW + 2;
   localparam int K  = NW + SH;
   localparam int PW = NW + MW;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [NW-1:0] num_ff, num_in;
   logic [PW-1:0] prod_ff;
   logic          go_ff;
   logic          done_ff;

   assign num_in   = go ? NW'(dividend) : num_ff;
   assign quotient = prod_ff[K +: RETRY_W];
   assign done     = done_ff;

   // latch the dividend, multiply by the scaled reciprocal, take the top bits
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         go_ff   <= go;
         done_ff <= go_ff;
      end
      num_ff  <= num_in;
      prod_ff <= PW'(num_ff) * PW'(RECIP);
   end

endmodule
`default_nettype wire

/* hdl/swfl_back.sv */
`default_nettype none
module swfl_back
   import swfl_pkg::*;
#(
   parameter int KEY_SLOTS = 256,
   parameter int STAMPS_PER_KEY = 16,
   parameter int TICKS_PER_SECOND = 1024,
   parameter int KW = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire logic                q_op,
   input  wire logic [KW-1:0]       q_key,
   input  wire logic [TIME_W-1:0]   q_now,
   output logic                     q_pop,
   input  wire logic [WINDOW_W-1:0] window,
   input  wire logic [MAXF_W-1:0]   max_fail,
   output logic                     clearing,
   output swfl_rsp_type             rsp
);

   localparam int S  = STAMPS_PER_KEY;
   localparam int SW = (S > 1) ? $clog2(S) : 1;
   localparam int CW = $clog2(S + 1);
   localparam int PW = CW + 1;
   localparam int AW = $clog2(KEY_SLOTS * S);
   localparam int WT = WINDOW_W + 17;
   localparam int MW = SW + CW;

   localparam logic [2:0] ST_CLR   = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_META  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   logic [TIME_W-1:0] stamp_mem [KEY_SLOTS * S];
   logic [MW-1:0]     meta_mem  [KEY_SLOTS];

   logic [2:0]        state_ff, state_in;
   logic [KW-1:0]     clr_ff, clr_in;
   logic              op_ff, op_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WT-1:0]     wt_ff;
   swfl_rsp_type      rsp_ff, rsp_in;

   logic [MW-1:0]     meta_rd_ff;
   logic [KW-1:0]     meta_ra;
   logic              meta_we;
   logic [KW-1:0]     meta_wa;
   logic [MW-1:0]     meta_wd;
   logic [TIME_W-1:0] stamp_rd_ff;
   logic [AW-1:0]     stamp_ra;
   logic              stamp_we;
   logic [AW-1:0]     stamp_wa;

   logic [SW-1:0]     meta_head;
   logic [CW-1:0]     meta_cnt;
   logic [TIME_W-1:0] age;
   logic              expired;
   logic [CW-1:0]     limit;
   logic [SW-1:0]     head_nx;
   logic [SW-1:0]     head_eff;
   logic [PW-1:0]     slot_sum;
   logic [SW-1:0]     slot;
   logic              div_go;
   logic              div_done;
   logic [RETRY_W-1:0] div_q;
   logic [RETRY_W-1:0] secs;

   assign meta_head = meta_rd_ff[MW-1:CW];
   assign meta_cnt  = meta_rd_ff[CW-1:0];
   assign age       = now_ff - stamp_rd_ff;
   assign expired   = (cnt_ff != '0) && (WT'(age) > wt_ff);
   assign head_nx   = (32'(head_ff) == S - 1) ? '0 : head_ff + SW'(1);
   assign head_eff  = (cnt_ff == '0) ? '0 : head_ff;
   assign slot_sum  = PW'(head_eff) + PW'(cnt_ff);
   assign slot      = (32'(slot_sum) >= S) ? SW'(slot_sum - PW'(S)) : SW'(slot_sum);
   assign secs      = (window - div_q == '0) ? RETRY_W'(1) : window - div_q;
   assign clearing  = (state_ff == ST_CLR);
   assign rsp       = rsp_ff;

   // clamp the threshold to one .. ring capacity
   always_comb begin
      if (max_fail == '0) begin
         limit = CW'(1);
      end else if (32'(max_fail) > S) begin
         limit = CW'(S);
      end else begin
         limit = CW'(max_fail);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      now_in   = now_ff;
      base_in  = base_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      rsp_in   = '0;
      q_pop    = 1'b0;
      meta_ra  = q_key;
      meta_we  = 1'b0;
      meta_wa  = key_ff;
      meta_wd  = '0;
      stamp_ra = base_ff + AW'(head_nx);
      stamp_we = 1'b0;
      stamp_wa = base_ff + AW'(slot);
      div_go   = 1'b0;
      case (state_ff)
         ST_CLR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            clr_in  = clr_ff + KW'(1);
            if (32'(clr_ff) == KEY_SLOTS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_op;
               key_in   = q_key;
               now_in   = q_now;
               base_in  = AW'(q_key) * AW'(S);
               state_in = ST_META;
            end
         end
         ST_META: begin
            stamp_ra = base_ff + AW'(meta_head);
            if (op_ff == OP_CLEAR) begin
               meta_we       = 1'b1;
               rsp_in.valid  = 1'b1;
               rsp_in.status = STATUS_CLEARED;
               state_in      = ST_IDLE;
            end else begin
               head_in  = meta_head;
               cnt_in   = meta_cnt;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (expired) begin
               // drop the oldest stamp, fetch the next one
               head_in = head_nx;
               cnt_in  = cnt_ff - CW'(1);
            end else if (cnt_ff >= limit) begin
               meta_we  = 1'b1;
               meta_wd  = {head_eff, cnt_ff};
               div_go   = 1'b1;
               state_in = ST_DIV;
            end else begin
               stamp_we      = 1'b1;
               meta_we       = 1'b1;
               meta_wd       = {head_eff, cnt_ff + CW'(1)};
               rsp_in.valid  = 1'b1;
               rsp_in.status = STATUS_ALLOWED;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_in.valid  = 1'b1;
               rsp_in.status = STATUS_BLOCKED;
               rsp_in.retry  = secs;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_ff   <= rsp_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      now_ff  <= now_in;
      base_ff <= base_in;
      head_ff <= head_in;
      cnt_ff  <= cnt_in;
      wt_ff   <= WT'(window) * WT'(TICKS_PER_SECOND);
   end

   // ring head and count per key
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_rd_ff <= meta_mem[meta_ra];
   end

   // time stamp store
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_wa] <= now_ff;
      end
      stamp_rd_ff <= stamp_mem[stamp_ra];
   end

   // retry seconds: window minus whole seconds already gone
   swfl_div #(
      .DIVISOR(TICKS_PER_SECOND)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (age),
      .quotient (div_q),
      .done     (div_done)
   );

endmodule
`default_nettype wire

/* hdl/sliding_window_failure_limiter_unit.sv */
//  channel  ports                                          handshake
//  request  start, busy, req_op, req_key_id, req_now_ticks  start & !busy
//  response rsp_valid, rsp_status, rsp_retry_after_seconds  one-cycle strobe
//  config   csr_valid, csr_ready, csr_index, csr_wdata      valid & ready
//
//  Clear: read the ring state, write it empty. Attempt: read it, drop each
//  expired stamp (up to STAMPS_PER_KEY), then store the stamp, or for a
//  block run the reciprocal multiply for the seconds. After reset a pass
//  over all KEY_SLOTS rings empties them while busy is high. A two-entry
//  queue takes items while the back end works; the receiver cannot stall.
`default_nettype none
module sliding_window_failure_limiter_unit
   import swfl_pkg::*;
#(
   parameter int KEY_SLOTS = 256,
   parameter int STAMPS_PER_KEY = 16,
   parameter int TICKS_PER_SECOND = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_op,
   input  wire logic [KEYID_W-1:0]   req_key_id,
   input  wire logic [TIME_W-1:0]    req_now_ticks,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [RETRY_W-1:0]        rsp_retry_after_seconds,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WINDOW_W-1:0]  csr_wdata
);

   localparam int KW = $clog2(KEY_SLOTS);

   logic [WINDOW_W-1:0] window_ff;
   logic [MAXF_W-1:0]   maxf_ff;
   logic                clearing;
   logic                q_valid;
   logic                q_op;
   logic [KW-1:0]       q_key;
   logic [TIME_W-1:0]   q_now;
   logic                q_pop;
   swfl_rsp_type        rsp;

   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp.valid;
   assign rsp_status              = rsp.status;
   assign rsp_retry_after_seconds = rsp.retry;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         maxf_ff   <= MAXF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW:   window_ff <= csr_wdata;
            CSR_MAX_FAIL: maxf_ff   <= csr_wdata[MAXF_W-1:0];
            default:      window_ff <= window_ff;
         endcase
      end
   end

   swfl_front #(
      .KEY_SLOTS(KEY_SLOTS),
      .KW(KW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .clearing      (clearing),
      .busy          (busy),
      .req_op        (req_op),
      .req_key_id    (req_key_id),
      .req_now_ticks (req_now_ticks),
      .q_valid       (q_valid),
      .q_op          (q_op),
      .q_key         (q_key),
      .q_now         (q_now),
      .q_pop         (q_pop)
   );

   swfl_back #(
      .KEY_SLOTS(KEY_SLOTS),
      .STAMPS_PER_KEY(STAMPS_PER_KEY),
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .KW(KW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_op     (q_op),
      .q_key    (q_key),
      .q_now    (q_now),
      .q_pop    (q_pop),
      .window   (window_ff),
      .max_fail (maxf_ff),
      .clearing (clearing),
      .rsp      (rsp)
   );

endmodule
`default_nettype wire
